// ----- sv/u8sd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types, codes and sizes for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CodeW    = 21;
  localparam int unsigned LenW     = 3;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned PendW    = 2;
  localparam int unsigned TokBitsW = 7;

  localparam int unsigned MidDepthDef = 2;
  localparam int unsigned OutDepthDef = 2;

  // Lead byte templates
  localparam logic [1:0] ContTag  = 2'b10;
  localparam logic [2:0] Lead2Tag = 3'b110;
  localparam logic [3:0] Lead3Tag = 4'b1110;
  localparam logic [4:0] Lead4Tag = 5'b11110;

  // Smallest legal value per sequence length
  localparam logic [CodeW-1:0] Min2 = CodeW'(32'h80);
  localparam logic [CodeW-1:0] Min3 = CodeW'(32'h800);
  localparam logic [CodeW-1:0] Min4 = CodeW'(32'h10000);

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_LEAD = 3'd1,
    ST_BAD_CONT = 3'd2,
    ST_OVERLONG = 3'd3,
    ST_TRUNC    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    TOK_ASCII,
    TOK_LEAD,
    TOK_CONT,
    TOK_BAD
  } tok_kind_e;

  // Classified byte, as passed from front to back
  typedef struct packed {
    tok_kind_e             kind;
    logic [LenW-1:0]       len;
    logic [TokBitsW-1:0]   bits;
    logic                  last;
  } token_t;

  typedef struct packed {
    logic [CodeW-1:0] code_point;
    logic [LenW-1:0]  seq_length;
    status_e          status;
  } result_t;

  // Handshake between the back stage and the two queues around it
  typedef struct packed {
    logic tok_valid;
    logic res_full;
  } back_in_t;

  typedef struct packed {
    logic tok_pop;
    logic res_push;
  } back_out_t;

endpackage

// ----- sv/u8sd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_fifo
// Small register-based queue with full and empty flags.
// ----------------------------------------------------------------------------
module u8sd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- sv/u8sd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_front
// Byte classifier: sorts each byte into ASCII, lead, continuation or invalid
// and extracts its payload bits.
// ----------------------------------------------------------------------------
module u8sd_front (
  input  logic [u8sd_pkg::ByteW-1:0] data_byte_i,
  input  logic                       final_byte_i,
  output u8sd_pkg::token_t           token_o
);
  import u8sd_pkg::*;

  always_comb begin
    token_o.last = final_byte_i;
    token_o.len  = LenW'(1);
    token_o.bits = '0;
    token_o.kind = TOK_BAD;
    if (!data_byte_i[7]) begin
      token_o.kind = TOK_ASCII;
      token_o.bits = data_byte_i[6:0];
    end else if (data_byte_i[7:6] == ContTag) begin
      token_o.kind = TOK_CONT;
      token_o.bits = {1'b0, data_byte_i[5:0]};
    end else if (data_byte_i[7:5] == Lead2Tag) begin
      token_o.kind = TOK_LEAD;
      token_o.len  = LenW'(2);
      token_o.bits = {2'b0, data_byte_i[4:0]};
    end else if (data_byte_i[7:4] == Lead3Tag) begin
      token_o.kind = TOK_LEAD;
      token_o.len  = LenW'(3);
      token_o.bits = {3'b0, data_byte_i[3:0]};
    end else if (data_byte_i[7:3] == Lead4Tag) begin
      token_o.kind = TOK_LEAD;
      token_o.len  = LenW'(4);
      token_o.bits = {4'b0, data_byte_i[2:0]};
    end
  end

endmodule

// ----- sv/u8sd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_back
// Sequence assembler: tracks pending continuation bytes, accumulates the
// code point and produces one result per finished or failed sequence.
// ----------------------------------------------------------------------------
module u8sd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  u8sd_pkg::back_in_t  ctrl_i,
  input  u8sd_pkg::token_t    token_i,
  output u8sd_pkg::back_out_t ctrl_o,
  output u8sd_pkg::result_t   result_o
);
  import u8sd_pkg::*;

  logic [PendW-1:0] pend_q, pend_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [CodeW-1:0] acc_q, acc_d;

  logic             take;
  logic             emit;
  logic [CodeW-1:0] acc_next;
  logic [PendW-1:0] pend_next;
  logic [CodeW-1:0] min_val;

  // Consume a token only when the result queue can take whatever it yields
  assign take   = ctrl_i.tok_valid && !ctrl_i.res_full;
  assign ctrl_o = {take, take && emit};

  assign acc_next  = {acc_q[CodeW-7:0], token_i.bits[5:0]};
  assign pend_next = pend_q - PendW'(1);

  always_comb begin
    case (len_q)
      LenW'(2): min_val = Min2;
      LenW'(3): min_val = Min3;
      default:  min_val = Min4;
    endcase
  end

  always_comb begin
    emit                = 1'b0;
    result_o.code_point = '0;
    result_o.seq_length = LenW'(1);
    result_o.status     = ST_OK;
    pend_d              = pend_q;
    len_d               = len_q;
    acc_d               = acc_q;
    if (pend_q == '0) begin
      case (token_i.kind)
        TOK_ASCII: begin
          emit                = 1'b1;
          result_o.code_point = CodeW'(token_i.bits);
        end
        TOK_LEAD: begin
          if (token_i.last) begin
            emit                = 1'b1;
            result_o.seq_length = token_i.len;
            result_o.status     = ST_TRUNC;
          end else begin
            len_d  = token_i.len;
            pend_d = PendW'(token_i.len - LenW'(1));
            acc_d  = CodeW'(token_i.bits);
          end
        end
        default: begin
          emit            = 1'b1;
          result_o.status = ST_BAD_LEAD;
        end
      endcase
    end else if (token_i.kind != TOK_CONT) begin
      emit                = 1'b1;
      result_o.seq_length = len_q;
      result_o.status     = ST_BAD_CONT;
    end else if (pend_next == '0) begin
      emit                = 1'b1;
      result_o.seq_length = len_q;
      if (acc_next < min_val) begin
        result_o.status = ST_OVERLONG;
      end else begin
        result_o.code_point = acc_next;
      end
    end else if (token_i.last) begin
      emit                = 1'b1;
      result_o.seq_length = len_q;
      result_o.status     = ST_TRUNC;
    end else begin
      pend_d = pend_next;
      acc_d  = acc_next;
    end
    // Any result drops back to idle
    if (emit) begin
      pend_d = '0;
      len_d  = '0;
      acc_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      len_q  <= '0;
      acc_q  <= '0;
    end else if (take) begin
      pend_q <= pend_d;
      len_q  <= len_d;
      acc_q  <= acc_d;
    end
  end

endmodule

// ----- sv/utf8_stream_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to code point decoder with error reporting.
// ----------------------------------------------------------------------------
// Takes one byte per cycle and sustains that rate as long as results are
// popped. A byte is classified on transfer and lands in a two-entry queue;
// the assembler takes one classified byte a cycle, its combinational shift
// and minimum-value compare setting the pace, and writes any result into a
// two-entry result queue. With nothing queued ahead, the byte that completes
// a result is registered in the middle queue and the result then in the
// result queue, whose head drives the outputs. A full result queue stalls
// the assembler and, once the middle queue fills, raises full.
module utf8_stream_decoder #(
  parameter int unsigned MidDepth = u8sd_pkg::MidDepthDef,
  parameter int unsigned OutDepth = u8sd_pkg::OutDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [u8sd_pkg::ByteW-1:0]   data_byte_i,
  input  logic                         final_byte_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [u8sd_pkg::CodeW-1:0]   code_point_o,
  output logic [u8sd_pkg::LenW-1:0]    seq_length_o,
  output logic [u8sd_pkg::StatusW-1:0] status_o
);
  import u8sd_pkg::*;

  token_t    tok_in, tok_out;
  result_t   res_in, res_out;
  back_in_t  back_in;
  back_out_t back_out;
  logic      mid_empty;
  logic      res_full;

  u8sd_front u_front (
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .token_o      (tok_in)
  );

  u8sd_fifo #(
    .Width ($bits(token_t)),
    .Depth (MidDepth)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (tok_in),
    .full_o  (full),
    .pop_i   (back_out.tok_pop),
    .rdata_o (tok_out),
    .empty_o (mid_empty)
  );

  assign back_in = {!mid_empty, res_full};

  u8sd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (back_in),
    .token_i  (tok_out),
    .ctrl_o   (back_out),
    .result_o (res_in)
  );

  u8sd_fifo #(
    .Width ($bits(result_t)),
    .Depth (OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_out.res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign code_point_o = res_out.code_point;
  assign seq_length_o = res_out.seq_length;
  assign status_o     = res_out.status;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
// A clocked driver offers bytes from a pending queue and decodes each
// transferred byte in a local model of the decoder. The expected code points
// and error results go into a queue. A clocked monitor pops results at random
// and compares each one, field by field, with the oldest expected result.
// Stimulus is a short directed string set followed by random strings: mostly
// well-formed sequences, some cut short, corrupted or overlong, plus noise.
// ----------------------------------------------------------------------------
module tb_top;
  import u8sd_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] value;
    logic             fin;
  } stream_byte_t;

  localparam int unsigned RxHoldCycles = 200;

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                push         = 1'b0;
  logic                full;
  logic [ByteW-1:0]    data_byte_i  = '0;
  logic                final_byte_i = 1'b0;
  logic                empty;
  logic                pop          = 1'b0;
  logic [CodeW-1:0]    code_point_o;
  logic [LenW-1:0]     seq_length_o;
  logic [StatusW-1:0]  status_o;

  stream_byte_t        byte_q[$];
  result_t             expected_results[$];

  // Decoder state as seen by the model
  logic [PendW-1:0]    conts_left;
  logic [LenW-1:0]     decl_len;
  logic [CodeW-1:0]    cp_acc;

  int unsigned         tx_gap;
  int unsigned         rx_gap;
  int unsigned         rx_hold_left;
  bit                  rx_hold_go;
  bit                  rx_hold_taken;
  bit                  steady;
  int unsigned         mismatches;

  utf8_stream_decoder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .empty        (empty),
    .pop          (pop),
    .code_point_o (code_point_o),
    .seq_length_o (seq_length_o),
    .status_o     (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("utf8_stream_decoder: mismatch");
    $finish;
  end

  function automatic int unsigned idle_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Decode one transferred byte and queue the result it causes, if any
  function automatic void decode_byte(input logic [ByteW-1:0] b, input logic last);
    result_t          r;
    bit               done;
    logic [LenW-1:0]  lead_len;
    logic [CodeW-1:0] lead_bits;
    logic [CodeW-1:0] floor_val;
    r         = '0;
    done      = 1'b0;
    lead_len  = '0;
    lead_bits = '0;
    if (conts_left == '0) begin
      if (!b[7]) begin
        r.code_point = CodeW'(b[6:0]);
        r.seq_length = LenW'(1);
        r.status     = ST_OK;
        done         = 1'b1;
      end else begin
        if (b[7:5] == Lead2Tag) begin
          lead_len  = LenW'(2);
          lead_bits = CodeW'(b[4:0]);
        end else if (b[7:4] == Lead3Tag) begin
          lead_len  = LenW'(3);
          lead_bits = CodeW'(b[3:0]);
        end else if (b[7:3] == Lead4Tag) begin
          lead_len  = LenW'(4);
          lead_bits = CodeW'(b[2:0]);
        end
        if (lead_len == '0) begin
          r.seq_length = LenW'(1);
          r.status     = ST_BAD_LEAD;
          done         = 1'b1;
        end else if (last) begin
          r.seq_length = lead_len;
          r.status     = ST_TRUNC;
          done         = 1'b1;
        end else begin
          decl_len   = lead_len;
          conts_left = PendW'(lead_len - 1);
          cp_acc     = lead_bits;
        end
      end
    end else if (b[7:6] != ContTag) begin
      r.seq_length = decl_len;
      r.status     = ST_BAD_CONT;
      done         = 1'b1;
    end else begin
      cp_acc     = {cp_acc[CodeW-7:0], b[5:0]};
      conts_left = conts_left - 1'b1;
      if (conts_left == '0) begin
        floor_val = (decl_len == LenW'(2)) ? Min2 :
                    (decl_len == LenW'(3)) ? Min3 : Min4;
        r.seq_length = decl_len;
        if (cp_acc < floor_val) begin
          r.status = ST_OVERLONG;
        end else begin
          r.code_point = cp_acc;
          r.status     = ST_OK;
        end
        done = 1'b1;
      end else if (last) begin
        r.seq_length = decl_len;
        r.status     = ST_TRUNC;
        done         = 1'b1;
      end
    end
    if (done) begin
      expected_results.push_back(r);
      conts_left = '0;
      decl_len   = '0;
      cp_acc     = '0;
    end
  endfunction

  function automatic void add_byte(input logic [ByteW-1:0] b, input logic fin);
    stream_byte_t item;
    item.value = b;
    item.fin   = fin;
    byte_q.push_back(item);
  endfunction

  // Encode cp in len bytes, keep the first keep of them, optionally spoil one
  // continuation byte, and if fin is set flag the last kept byte as string end
  function automatic void add_sequence(input int unsigned len, input logic [CodeW-1:0] cp,
                                       input int unsigned keep, input bit spoil,
                                       input bit fin);
    logic [ByteW-1:0] seq[4];
    logic [ByteW-1:0] bad;
    int unsigned      j;
    case (len)
      1: seq[0] = {1'b0, cp[6:0]};
      2: seq[0] = {Lead2Tag, cp[10:6]};
      3: seq[0] = {Lead3Tag, cp[15:12]};
      default: seq[0] = {Lead4Tag, cp[20:18]};
    endcase
    for (int i = 1; i < len; i++) begin
      seq[i] = {ContTag, cp[6*(len-1-i) +: 6]};
    end
    if (spoil && keep > 1) begin
      j   = $urandom_range(1, keep - 1);
      bad = ByteW'($urandom_range(0, 255));
      if (bad[7:6] == ContTag) bad[6] = 1'b1;
      seq[j] = bad;
    end
    for (int i = 0; i < keep; i++) begin
      add_byte(seq[i], fin && (i == keep - 1));
    end
  endfunction

  function automatic void add_random_strings(input int unsigned n_bytes);
    int unsigned      goal;
    int unsigned      sel;
    int unsigned      len;
    int unsigned      keep;
    bit               spoil;
    bit               fin;
    logic [CodeW-1:0] cp;
    goal = byte_q.size() + n_bytes;
    while (byte_q.size() < goal) begin
      sel = $urandom_range(0, 99);
      fin = ($urandom_range(0, 7) == 0);
      if (sel < 8) begin
        add_byte(ByteW'($urandom_range(0, 255)), fin);
      end else begin
        len   = $urandom_range(1, 4);
        keep  = len;
        spoil = 1'b0;
        if ($urandom_range(0, 3) == 0) begin
          // below the legal floor: overlong for any multi-byte length
          case (len)
            1, 2:    cp = CodeW'($urandom_range(0, 'h7F));
            3:       cp = CodeW'($urandom_range(0, 'h7FF));
            default: cp = CodeW'($urandom_range(0, 'hFFFF));
          endcase
        end else begin
          case (len)
            1:       cp = CodeW'($urandom_range(0, 'h7F));
            2:       cp = CodeW'($urandom_range('h80, 'h7FF));
            3:       cp = CodeW'($urandom_range('h800, 'hFFFF));
            default: cp = CodeW'($urandom_range('h10000, 'h1FFFFF));
          endcase
        end
        if (sel < 16) keep = $urandom_range(1, len);
        else if (sel < 24) spoil = 1'b1;
        add_sequence(len, cp, keep, spoil, fin);
      end
    end
  endfunction

  // Hold until every byte is transferred and every expected result is back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (byte_q.size() != 0 || push || expected_results.size() != 0);
  endtask

  // Driver: hold push until transfer, then take the next byte after a gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push       <= 1'b0;
      tx_gap     <= 0;
      conts_left = '0;
      decl_len   = '0;
      cp_acc     = '0;
    end else begin
      if (push && !full) decode_byte(data_byte_i, final_byte_i);
      if (!push || !full) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          push   <= 1'b0;
        end else if (byte_q.size() != 0) begin
          stream_byte_t item;
          item = byte_q.pop_front();
          data_byte_i  <= item.value;
          final_byte_i <= item.fin;
          push         <= 1'b1;
          tx_gap       <= idle_gap();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here and seen by the monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_hold_left  <= 0;
      rx_hold_taken <= 1'b0;
    end else if (rx_hold_go && !rx_hold_taken) begin
      rx_hold_left  <= RxHoldCycles;
      rx_hold_taken <= 1'b1;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // Monitor: check each transferred result against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop    <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (pop && !empty) begin
        result_t want;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: cp %h len %0d status %0d",
                     code_point_o, seq_length_o, status_o);
        end else begin
          want = expected_results.pop_front();
          if (code_point_o !== want.code_point || seq_length_o !== want.seq_length ||
              status_o !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result differs: cp %h/%h len %0d/%0d status %0d/%0d (got/want)",
                       code_point_o, want.code_point, seq_length_o, want.seq_length,
                       status_o, want.status);
          end
        end
      end
      if (rx_hold_left != 0) begin
        pop <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap <= rx_gap - 1;
        pop    <= 1'b0;
      end else begin
        pop    <= 1'b1;
        rx_gap <= idle_gap();
      end
    end
  end

  initial begin
    mismatches    = 0;
    steady        = 1'b0;
    rx_hold_go    = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // ASCII extremes, invalid leads
    add_byte(8'h00, 1'b0);
    add_byte(8'h7F, 1'b1);
    add_byte(8'h80, 1'b0);
    add_byte(8'hFF, 1'b1);
    // shortest legal form of each length, overlong two- and three-byte forms
    add_byte(8'hC1, 1'b0); add_byte(8'hBF, 1'b0);
    add_byte(8'hC2, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'hE0, 1'b0); add_byte(8'hA0, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'hE0, 1'b0); add_byte(8'h9F, 1'b0); add_byte(8'hBF, 1'b0);
    add_byte(8'hF0, 1'b0); add_byte(8'h90, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'h80, 1'b0);
    // bad continuation, also on the final byte
    add_byte(8'hE2, 1'b0); add_byte(8'h41, 1'b0);
    add_byte(8'hC3, 1'b0); add_byte(8'h41, 1'b1);
    // string ends on a lead byte, then mid-sequence
    add_byte(8'hE2, 1'b1);
    add_byte(8'hF0, 1'b0); add_byte(8'h90, 1'b1);
    wait_drained();

    add_random_strings(250);
    wait_drained();
    repeat (4) @(negedge clk_i);

    // stall the receiver while the sender keeps offering bytes
    rx_hold_go = 1'b1;
    add_random_strings(250);
    wait_drained();
    repeat (4) @(negedge clk_i);

    steady = 1'b1;
    add_random_strings(120);
    wait_drained();
    steady = 1'b0;
    add_random_strings(130);
    wait_drained();
    repeat (20) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("utf8_stream_decoder: match");
    end else begin
      $display("utf8_stream_decoder: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/u8sd_pkg.sv
sv/u8sd_fifo.sv
sv/u8sd_front.sv
sv/u8sd_back.sv
sv/utf8_stream_decoder.sv
tb/tb_top.sv
